// ===== src/brent_line_minimizer_unit_defines.svh =====
// Assertion macros for the Brent line minimizer unit.
// Expects clk and rst_n in the scope of use.
`ifndef BRENT_LINE_MINIMIZER_UNIT_DEFINES_SVH
`define BRENT_LINE_MINIMIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/blm_pkg.sv =====
// Shared types, constants and saturating fixed-point helpers for the
// Brent line minimizer. No dependencies.
package blm_pkg;

  localparam int VW = 32;
  localparam int FB = 16;

  localparam logic signed [VW-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VW-1:0] VMIN = 32'sh8000_0000;
  localparam logic [63:0] LIM64 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [VW-1:0] GOLDEN = 32'h61C8_8647;
  localparam int DIV_BITS = VW + FB;

  localparam logic [1:0] CFG_ABS_TOL    = 2'd0;
  localparam logic [1:0] CFG_REL_TOL    = 2'd1;
  localparam logic [1:0] CFG_ITER_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    KIND_PROBE   = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_LIMIT   = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_CAPTURE, OP_ST_ORDER, OP_ST_MUL, OP_ST_SET, OP_LD_FIRST, OP_ABSORB,
    OP_PL0, OP_PL1, OP_PL2, OP_R_MUL, OP_R_SET, OP_Q_MUL, OP_Q_SET, OP_PA_MUL,
    OP_PA_SET, OP_PB_MUL, OP_PB_SET, OP_Q_DBL, OP_SIGN, OP_TA_MUL, OP_TA_SET,
    OP_TB_MUL, OP_TB_SET, OP_TC_MUL, OP_TC_SET, OP_DIV_START, OP_DIV_STEP,
    OP_E_SET, OP_U_TRY, OP_U_FIX, OP_G_D, OP_G_MUL, OP_G_E, OP_FINAL
  } op_t;

  typedef struct packed {
    op_t   op;
    logic  load_out;
    kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic lim_hit;
    logic conv;
    logic d_big;
    logic p_accept;
    logic div_done;
  } dp_stat_t;

  function automatic logic signed [VW-1:0] sat_add(logic signed [VW-1:0] a,
                                                   logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
    return s[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sat_sub(logic signed [VW-1:0] a,
                                                   logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
    return s[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] mag32(logic signed [VW-1:0] a);
    return a[VW-1] ? VW'(-a) : VW'(a);
  endfunction

  // Signed value from sign and magnitude, saturated.
  function automatic logic signed [VW-1:0] from_mag(logic neg, logic [63:0] m);
    if (m > LIM64) return neg ? VMIN : VMAX;
    if (neg) return -$signed(m[VW-1:0]);
    return $signed(m[VW-1:0]);
  endfunction

endpackage

// ===== src/blm_datapath.sv =====
// Datapath of the Brent line minimizer: search state, shared 32x32
// multiplier, bit-serial divider, config and result registers. Uses blm_pkg.
module blm_datapath import blm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic signed [VW-1:0] in_range_low,
  input  logic signed [VW-1:0] in_range_high,
  input  logic signed [VW-1:0] in_function_value,
  output logic [1:0]           out_kind,
  output logic signed [VW-1:0] out_point,
  output logic signed [VW-1:0] out_best_value
);

  logic [15:0] abs_r, rel_r;
  logic [7:0]  lim_r, cnt_r;

  logic signed [VW-1:0] bl_r, bh_r, x_r, w_r, v_r, fx_r, fw_r, fv_r, e_r, d_r, u_r;
  logic signed [VW-1:0] lo_r, m_r, r_r, q_r, p_r, ta_r, tb_r, tc_r, tu_r;
  logic signed [VW-1:0] rlo_r, rhi_r, fin_r;
  logic [VW-1:0]        span_r, tol1_r;
  logic [VW+1:0]        acc_r;
  logic [63:0]          prod_r;
  logic                 neg_r;

  logic [DIV_BITS-1:0]  num_r, quot_r;
  logic [VW-1:0]        dv_r, rem_r;
  logic [5:0]           dcnt_r;

  kind_t                okind_r;
  logic signed [VW-1:0] opoint_r, obest_r;

  // multiplier operand selection
  logic signed [VW-1:0] sa, sb;
  logic [VW-1:0]        ma, mb;
  logic                 mneg, use_raw;

  always_comb begin
    sa = '0;
    sb = '0;
    use_raw = 1'b0;
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_ST_MUL: begin
        use_raw = 1'b1;
        ma = VW'(bh_r - bl_r);
        mb = GOLDEN;
      end
      OP_PL1: begin
        use_raw = 1'b1;
        ma = mag32(x_r);
        mb = {16'd0, rel_r};
      end
      OP_R_MUL: begin
        sa = sat_sub(x_r, w_r);
        sb = sat_sub(fx_r, fv_r);
      end
      OP_Q_MUL: begin
        sa = sat_sub(x_r, v_r);
        sb = sat_sub(fx_r, fw_r);
      end
      OP_PA_MUL: begin
        sa = sat_sub(x_r, v_r);
        sb = q_r;
      end
      OP_PB_MUL: begin
        sa = sat_sub(x_r, w_r);
        sb = r_r;
      end
      OP_TA_MUL: begin
        sa = q_r;
        sb = r_r;
      end
      OP_TB_MUL: begin
        sa = q_r;
        sb = sat_sub(bl_r, x_r);
      end
      OP_TC_MUL: begin
        sa = q_r;
        sb = sat_sub(bh_r, x_r);
      end
      OP_G_MUL: begin
        sa = d_r;
        sb = $signed(GOLDEN);
      end
      default: ;
    endcase
    if (!use_raw) begin
      ma = mag32(sa);
      mb = mag32(sb);
    end
    mneg = !use_raw && (sa[VW-1] != sb[VW-1]);
  end

  logic signed [VW-1:0] fm16, fm17, fm32;
  assign fm16 = from_mag(neg_r, prod_r >> FB);
  assign fm17 = from_mag(neg_r, prod_r >> (FB + 1));
  assign fm32 = from_mag(neg_r, prod_r >> 32);

  // tolerance and convergence distance
  logic [VW:0]          tsum;
  logic [VW-1:0]        tol1_nxt;
  logic signed [VW:0]   xm_diff;
  logic [VW:0]          dx;
  logic [VW:0]          tol2;
  logic signed [VW-1:0] t1_s;

  always_comb begin
    tsum = {1'b0, prod_r[VW+FB-1:FB]} + {17'd0, abs_r};
    tol1_nxt = (tsum > {1'b0, VW'(VMAX)}) ? VW'(VMAX) : tsum[VW-1:0];
    xm_diff = {x_r[VW-1], x_r} - {m_r[VW-1], m_r};
    dx = xm_diff[VW] ? (VW+1)'(-xm_diff) : (VW+1)'(xm_diff);
    tol2 = {tol1_r, 1'b0};
    t1_s = $signed(tol1_r);
  end

  function automatic logic below(logic signed [VW-1:0] diff, logic [VW:0] t2);
    return diff[VW-1] || ({1'b0, diff} < t2);
  endfunction

  logic                 near;
  logic [VW:0]          rem_sh;
  logic                 rem_ge;
  assign near = below(sat_sub(tu_r, bl_r), tol2) || below(sat_sub(bh_r, tu_r), tol2);
  assign rem_sh = {rem_r, num_r[DIV_BITS-1]};
  assign rem_ge = rem_sh >= {1'b0, dv_r};

  assign stat.lim_hit  = cnt_r >= lim_r;
  assign stat.conv     = acc_r <= {1'b0, tol2};
  assign stat.d_big    = mag32(d_r) > tol1_r;
  assign stat.p_accept = (mag32(p_r) < mag32(ta_r)) && (p_r > tb_r) && (p_r < tc_r);
  assign stat.div_done = dcnt_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_r <= 16'd4;
      rel_r <= 16'd1;
      lim_r <= 8'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ABS_TOL:    abs_r <= cfg_data;
        CFG_REL_TOL:    rel_r <= cfg_data;
        CFG_ITER_LIMIT: lim_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ST_MUL || cmd.op == OP_PL1 || cmd.op == OP_R_MUL ||
        cmd.op == OP_Q_MUL || cmd.op == OP_PA_MUL || cmd.op == OP_PB_MUL ||
        cmd.op == OP_TA_MUL || cmd.op == OP_TB_MUL || cmd.op == OP_TC_MUL ||
        cmd.op == OP_G_MUL) begin
      prod_r <= ma * mb;
      neg_r  <= mneg;
    end
    unique case (cmd.op)
      OP_CAPTURE: begin
        rlo_r <= in_range_low;
        rhi_r <= in_range_high;
        fin_r <= in_function_value;
      end
      OP_ST_ORDER: begin
        bl_r <= (rlo_r > rhi_r) ? rhi_r : rlo_r;
        bh_r <= (rlo_r > rhi_r) ? rlo_r : rhi_r;
      end
      OP_ST_SET: begin
        x_r <= bl_r + $signed(prod_r[63:32]);
        w_r <= bl_r + $signed(prod_r[63:32]);
        v_r <= bl_r + $signed(prod_r[63:32]);
        u_r <= bl_r + $signed(prod_r[63:32]);
        fx_r <= '0;
        fw_r <= '0;
        fv_r <= '0;
        e_r <= '0;
        d_r <= '0;
        cnt_r <= '0;
      end
      OP_LD_FIRST: begin
        fx_r <= fin_r;
        fw_r <= fin_r;
        fv_r <= fin_r;
      end
      OP_ABSORB: begin
        if (fin_r <= fx_r) begin
          if (u_r < x_r) bh_r <= x_r;
          else bl_r <= x_r;
          v_r <= w_r;
          fv_r <= fw_r;
          w_r <= x_r;
          fw_r <= fx_r;
          x_r <= u_r;
          fx_r <= fin_r;
        end else begin
          if (u_r < x_r) bl_r <= u_r;
          else bh_r <= u_r;
          if (fin_r <= fw_r || w_r == x_r) begin
            v_r <= w_r;
            fv_r <= fw_r;
            w_r <= u_r;
            fw_r <= fin_r;
          end else if (fin_r <= fv_r || v_r == x_r || v_r == w_r) begin
            v_r <= u_r;
            fv_r <= fin_r;
          end
        end
        if (cnt_r != 8'hFF) cnt_r <= cnt_r + 8'd1;
      end
      OP_PL0: begin
        lo_r   <= (bl_r < bh_r) ? bl_r : bh_r;
        span_r <= (bl_r < bh_r) ? VW'(bh_r - bl_r) : VW'(bl_r - bh_r);
      end
      OP_PL1: m_r <= lo_r + $signed({1'b0, span_r[VW-1:1]});
      OP_PL2: begin
        tol1_r <= tol1_nxt;
        acc_r  <= {1'b0, dx} + {3'd0, span_r[VW-1:1]};
      end
      OP_R_SET:  r_r <= fm16;
      OP_Q_SET:  q_r <= fm16;
      OP_PA_SET: p_r <= fm16;
      OP_PB_SET: begin
        p_r <= sat_sub(p_r, fm16);
        q_r <= sat_sub(q_r, r_r);
      end
      OP_Q_DBL: q_r <= sat_add(q_r, q_r);
      OP_SIGN: begin
        if (q_r > 0) p_r <= sat_sub('0, p_r);
        else q_r <= sat_sub('0, q_r);
        r_r <= d_r;
        d_r <= e_r;
      end
      OP_TA_SET: ta_r <= fm17;
      OP_TB_SET: tb_r <= fm16;
      OP_TC_SET: tc_r <= fm16;
      OP_DIV_START: begin
        num_r  <= {mag32(p_r), FB'(0)};
        dv_r   <= mag32(q_r);
        rem_r  <= '0;
        quot_r <= '0;
        dcnt_r <= 6'(DIV_BITS);
      end
      OP_DIV_STEP: begin
        // restoring division, one quotient bit per cycle
        rem_r  <= rem_ge ? VW'(rem_sh - {1'b0, dv_r}) : rem_sh[VW-1:0];
        quot_r <= {quot_r[DIV_BITS-2:0], rem_ge};
        num_r  <= {num_r[DIV_BITS-2:0], 1'b0};
        dcnt_r <= dcnt_r - 6'd1;
      end
      OP_E_SET: e_r <= (q_r == '0) ? '0 : from_mag(p_r[VW-1], 64'(quot_r));
      OP_U_TRY: tu_r <= sat_add(x_r, e_r);
      OP_U_FIX: if (near) e_r <= (x_r < m_r) ? t1_s : -t1_s;
      OP_G_D:   d_r <= (x_r < m_r) ? sat_sub(bh_r, x_r) : sat_sub(bl_r, x_r);
      OP_G_E:   e_r <= fm32;
      OP_FINAL: begin
        if (mag32(e_r) >= tol1_r) u_r <= sat_add(x_r, e_r);
        else if (e_r > 0) u_r <= sat_add(x_r, t1_s);
        else u_r <= sat_sub(x_r, t1_s);
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      okind_r <= cmd.kind;
      unique case (cmd.kind)
        KIND_PROBE: begin
          opoint_r <= u_r;
          obest_r  <= '0;
        end
        KIND_DONE, KIND_LIMIT: begin
          opoint_r <= x_r;
          obest_r  <= fx_r;
        end
        KIND_IGNORED: begin
          opoint_r <= '0;
          obest_r  <= '0;
        end
      endcase
    end
  end

  assign out_kind       = okind_r;
  assign out_point      = opoint_r;
  assign out_best_value = obest_r;

endmodule

// ===== src/blm_ctrl.sv =====
// Controller of the Brent line minimizer: sequences datapath operations
// and owns the handshakes and search phase. Uses blm_pkg.
module blm_ctrl import blm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_cmd,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int NS = 37;

  typedef enum logic [NS-1:0] {
    S_WAIT     = NS'(1) << 0,  S_ORDER   = NS'(1) << 1,  S_ST_MUL  = NS'(1) << 2,
    S_ST_SET   = NS'(1) << 3,  S_LD_FIRST = NS'(1) << 4, S_ABSORB  = NS'(1) << 5,
    S_PL0      = NS'(1) << 6,  S_PL1     = NS'(1) << 7,  S_PL2     = NS'(1) << 8,
    S_PCHK     = NS'(1) << 9,  S_R_MUL   = NS'(1) << 10, S_R_SET   = NS'(1) << 11,
    S_Q_MUL    = NS'(1) << 12, S_Q_SET   = NS'(1) << 13, S_PA_MUL  = NS'(1) << 14,
    S_PA_SET   = NS'(1) << 15, S_PB_MUL  = NS'(1) << 16, S_PB_SET  = NS'(1) << 17,
    S_Q_DBL    = NS'(1) << 18, S_SIGN    = NS'(1) << 19, S_TA_MUL  = NS'(1) << 20,
    S_TA_SET   = NS'(1) << 21, S_TB_MUL  = NS'(1) << 22, S_TB_SET  = NS'(1) << 23,
    S_TC_MUL   = NS'(1) << 24, S_TC_SET  = NS'(1) << 25, S_PTEST   = NS'(1) << 26,
    S_DIV_START = NS'(1) << 27, S_DIV_RUN = NS'(1) << 28, S_E_SET  = NS'(1) << 29,
    S_U_TRY    = NS'(1) << 30, S_U_FIX   = NS'(1) << 31, S_G_D     = NS'(1) << 32,
    S_G_MUL    = NS'(1) << 33, S_G_E     = NS'(1) << 34, S_FINAL   = NS'(1) << 35,
    S_EMIT     = NS'(1) << 36
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_FIRST = 3'b010,
    PH_PROBE = 3'b100
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  kind_t  kind_r, kind_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    cmd.op    = OP_NOP;
    cmd.load_out = 1'b0;
    cmd.kind  = kind_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_CAPTURE;
          if (!in_cmd) state_nxt = S_ORDER;
          else begin
            unique case (phase_r)
              PH_FIRST: state_nxt = S_LD_FIRST;
              PH_PROBE: state_nxt = S_ABSORB;
              default: begin
                kind_nxt  = KIND_IGNORED;
                state_nxt = S_EMIT;
              end
            endcase
          end
        end
      end
      S_ORDER:  begin cmd.op = OP_ST_ORDER; state_nxt = S_ST_MUL; end
      S_ST_MUL: begin cmd.op = OP_ST_MUL;   state_nxt = S_ST_SET; end
      S_ST_SET: begin
        cmd.op = OP_ST_SET;
        phase_nxt = PH_FIRST;
        kind_nxt = KIND_PROBE;
        state_nxt = S_EMIT;
      end
      S_LD_FIRST: begin cmd.op = OP_LD_FIRST; state_nxt = S_PL0; end
      S_ABSORB:   begin cmd.op = OP_ABSORB;   state_nxt = S_PL0; end
      S_PL0: begin
        // iteration limit is checked before anything else
        if (stat.lim_hit) begin
          phase_nxt = PH_IDLE;
          kind_nxt = KIND_LIMIT;
          state_nxt = S_EMIT;
        end else begin
          cmd.op = OP_PL0;
          state_nxt = S_PL1;
        end
      end
      S_PL1: begin cmd.op = OP_PL1; state_nxt = S_PL2; end
      S_PL2: begin cmd.op = OP_PL2; state_nxt = S_PCHK; end
      S_PCHK: begin
        if (stat.conv) begin
          phase_nxt = PH_IDLE;
          kind_nxt = KIND_DONE;
          state_nxt = S_EMIT;
        end else if (stat.d_big) state_nxt = S_R_MUL;
        else state_nxt = S_G_D;
      end
      S_R_MUL:  begin cmd.op = OP_R_MUL;  state_nxt = S_R_SET;  end
      S_R_SET:  begin cmd.op = OP_R_SET;  state_nxt = S_Q_MUL;  end
      S_Q_MUL:  begin cmd.op = OP_Q_MUL;  state_nxt = S_Q_SET;  end
      S_Q_SET:  begin cmd.op = OP_Q_SET;  state_nxt = S_PA_MUL; end
      S_PA_MUL: begin cmd.op = OP_PA_MUL; state_nxt = S_PA_SET; end
      S_PA_SET: begin cmd.op = OP_PA_SET; state_nxt = S_PB_MUL; end
      S_PB_MUL: begin cmd.op = OP_PB_MUL; state_nxt = S_PB_SET; end
      S_PB_SET: begin cmd.op = OP_PB_SET; state_nxt = S_Q_DBL;  end
      S_Q_DBL:  begin cmd.op = OP_Q_DBL;  state_nxt = S_SIGN;   end
      S_SIGN:   begin cmd.op = OP_SIGN;   state_nxt = S_TA_MUL; end
      S_TA_MUL: begin cmd.op = OP_TA_MUL; state_nxt = S_TA_SET; end
      S_TA_SET: begin cmd.op = OP_TA_SET; state_nxt = S_TB_MUL; end
      S_TB_MUL: begin cmd.op = OP_TB_MUL; state_nxt = S_TB_SET; end
      S_TB_SET: begin cmd.op = OP_TB_SET; state_nxt = S_TC_MUL; end
      S_TC_MUL: begin cmd.op = OP_TC_MUL; state_nxt = S_TC_SET; end
      S_TC_SET: begin cmd.op = OP_TC_SET; state_nxt = S_PTEST;  end
      S_PTEST:  state_nxt = stat.p_accept ? S_DIV_START : S_G_D;
      S_DIV_START: begin cmd.op = OP_DIV_START; state_nxt = S_DIV_RUN; end
      S_DIV_RUN: begin
        if (stat.div_done) state_nxt = S_E_SET;
        else cmd.op = OP_DIV_STEP;
      end
      S_E_SET: begin cmd.op = OP_E_SET; state_nxt = S_U_TRY; end
      S_U_TRY: begin cmd.op = OP_U_TRY; state_nxt = S_U_FIX; end
      S_U_FIX: begin cmd.op = OP_U_FIX; state_nxt = S_FINAL; end
      S_G_D:   begin cmd.op = OP_G_D;   state_nxt = S_G_MUL; end
      S_G_MUL: begin cmd.op = OP_G_MUL; state_nxt = S_G_E;   end
      S_G_E:   begin cmd.op = OP_G_E;   state_nxt = S_FINAL; end
      S_FINAL: begin
        cmd.op = OP_FINAL;
        phase_nxt = PH_PROBE;
        kind_nxt = KIND_PROBE;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      phase_r     <= PH_IDLE;
      kind_r      <= KIND_PROBE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/brent_line_minimizer_unit.sv =====
// Brent line minimizer unit, top level: controller plus datapath. Uses blm_pkg.
// A parabolic step outlasts a golden step; the bit-serial divider dominates.
// One transaction in flight; the next is taken once the result is in the
// output register. Synchronous active-low reset: idle, default tolerances.
module brent_line_minimizer_unit import blm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic signed [VW-1:0] in_range_low,
  input  logic signed [VW-1:0] in_range_high,
  input  logic signed [VW-1:0] in_function_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic signed [VW-1:0] out_point,
  output logic signed [VW-1:0] out_best_value
);

  `include "brent_line_minimizer_unit_defines.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  blm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  blm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_range_low      (in_range_low),
    .in_range_high     (in_range_high),
    .in_function_value (in_function_value),
    .out_kind          (out_kind),
    .out_point         (out_point),
    .out_best_value    (out_best_value)
  );

  `BLM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `BLM_ASSERT_IMP(a_div_busy, cmd.op == OP_DIV_STEP, !in_ready, "input taken mid-divide")
  `BLM_ASSERT_IMP(a_quot_ready, cmd.op == OP_E_SET, stat.div_done, "quotient used early")
  `BLM_ASSERT_IMP(a_probe_zero, out_valid && out_kind == KIND_PROBE, out_best_value == 0, "probe value nonzero")

endmodule
